// ===== rtl/lpdc_pkg.sv =====
// Shared constants for the lever press duration classifier.
`default_nettype none

package lpdc_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned TickW    = 10;
  localparam int unsigned FlagW    = 4;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned NumLeversDefault = 2;

  // Lever status codes.
  localparam logic [StatusW-1:0] ST_IDLE    = 2'd0;
  localparam logic [StatusW-1:0] ST_PUSHED  = 2'd1;
  localparam logic [StatusW-1:0] ST_POPPED  = 2'd2;
  localparam logic [StatusW-1:0] ST_TIMEOUT = 2'd3;

  // Event flag bits.
  localparam logic [FlagW-1:0] FL_SHORT     = 4'b0001;
  localparam logic [FlagW-1:0] FL_LONG      = 4'b0010;
  localparam logic [FlagW-1:0] FL_VLONG     = 4'b0100;
  localparam logic [FlagW-1:0] FL_POP       = 4'b1000;
  localparam logic [FlagW-1:0] FL_PRESS_ALL = 4'b0111;

  // Request kinds.
  localparam logic KIND_SCAN  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SHORT_THR = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_THR  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_VLONG_THR = 2'd2;

  localparam logic [TickW-1:0] SHORT_THR_RESET = 10'd10;
  localparam logic [TickW-1:0] LONG_THR_RESET  = 10'd200;
  localparam logic [TickW-1:0] VLONG_THR_RESET = 10'd800;
  localparam logic [TickW-1:0] TICK_MAX        = 10'd1023;

endpackage

`default_nettype wire

// ===== rtl/lpdc_if.sv =====
// Valid/ready channel interfaces for requests, results and configuration writes.
`default_nettype none

interface lpdc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        lever_id;
  logic [15:0] sample;
  logic [3:0]  flag_mask;

  modport source (output valid, kind, lever_id, sample, flag_mask, input ready);
  modport sink   (input valid, kind, lever_id, sample, flag_mask, output ready);
endinterface

interface lpdc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] lever_value;
  logic [3:0]  event_flags;
  logic [1:0]  lever_status;
  logic        masked_all_set;

  modport source (output valid, lever_value, event_flags, lever_status, masked_all_set,
                  input ready);
  modport sink   (input valid, lever_value, event_flags, lever_status, masked_all_set,
                  output ready);
endinterface

interface lpdc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [9:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lever_press_duration_classifier.sv =====
// Lever press duration classifier: per-lever press timing, flags and status.
// A request moves from the input register to the result register when that is free.
// Throughput: one request per cycle while results are taken, set by the single
// read-modify-write of the per-lever state between the input and result registers.
// Reset (rst, synchronous, active high) clears all lever state to idle and zero and
// loads the thresholds with 10, 200 and 800 ticks.
`default_nettype none

module lever_press_duration_classifier #(
  parameter int unsigned NUM_LEVERS = lpdc_pkg::NumLeversDefault
) (
  input  wire         clk,
  input  wire         rst,
  lpdc_in_if.sink     in_ch,
  lpdc_out_if.source  out_ch,
  lpdc_cfg_if.sink    cfg_ch
);
  import lpdc_pkg::*;

  localparam int unsigned IdxW = (NUM_LEVERS > 1) ? $clog2(NUM_LEVERS) : 1;

  // Threshold registers. The user must write these only while the block is idle;
  // the block does not enforce it, and the write port is always ready.
  logic [TickW-1:0] short_thr;
  logic [TickW-1:0] long_thr;
  logic [TickW-1:0] vlong_thr;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_thr <= SHORT_THR_RESET;
      long_thr  <= LONG_THR_RESET;
      vlong_thr <= VLONG_THR_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_SHORT_THR: short_thr <= cfg_ch.data;
        REG_LONG_THR:  long_thr  <= cfg_ch.data;
        REG_VLONG_THR: vlong_thr <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register stage. The stage moves on whenever the result register is
  // empty or its result is being taken, so a new request can enter every cycle.
  logic               in_valid;
  logic               in_kind;
  logic               in_lever;
  logic [SampleW-1:0] in_sample;
  logic [FlagW-1:0]   in_mask;
  logic               advance;

  logic               res_valid;

  assign advance     = !res_valid || out_ch.ready;
  assign in_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_kind   <= in_ch.kind;
      in_lever  <= in_ch.lever_id;
      in_sample <= in_ch.sample;
      in_mask   <= in_ch.flag_mask;
    end
  end

  // Per-lever state. It is written at the same edge as the result register, so
  // the next request already sees the updated context and needs no bypass.
  logic [SampleW-1:0] last_sample [NUM_LEVERS];
  logic [StatusW-1:0] press_status [NUM_LEVERS];
  logic [TickW-1:0]   press_ticks [NUM_LEVERS];
  logic [FlagW-1:0]   flag_bits [NUM_LEVERS];

  logic [IdxW-1:0]    idx;
  logic               id_ok;
  logic [SampleW-1:0] cur_sample;
  logic [StatusW-1:0] cur_status;
  logic [TickW-1:0]   cur_ticks;
  logic [FlagW-1:0]   cur_flags;

  logic [SampleW-1:0] sample_next;
  logic [StatusW-1:0] status_next;
  logic [TickW-1:0]   ticks_next;
  logic [FlagW-1:0]   flags_next;
  logic [TickW-1:0]   tick_inc;
  logic               do_step;

  assign idx     = IdxW'(in_lever);
  assign id_ok   = (32'(in_lever) < NUM_LEVERS);
  assign do_step = in_valid && advance;

  assign cur_sample = last_sample[idx];
  assign cur_status = press_status[idx];
  assign cur_ticks  = press_ticks[idx];
  assign cur_flags  = flag_bits[idx];

  always_comb begin
    sample_next = cur_sample;
    status_next = cur_status;
    ticks_next  = cur_ticks;
    flags_next  = cur_flags;
    tick_inc    = '0;

    if (in_kind == KIND_SCAN) begin
      // A changed reading either starts a new press or ends the current one.
      if (cur_sample != in_sample) begin
        sample_next = in_sample;
        if (in_sample != '0) begin
          status_next = ST_PUSHED;
          ticks_next  = '0;
          flags_next  = cur_flags & ~FL_PRESS_ALL;
        end else if (cur_ticks >= short_thr) begin
          status_next = ST_POPPED;
          flags_next  = cur_flags | FL_POP;
        end else begin
          status_next = ST_IDLE;
        end
      end

      // While held, count ticks (saturating) and raise one duration flag at most,
      // very long first, then long, then short.
      if (status_next == ST_PUSHED) begin
        tick_inc   = (ticks_next < TICK_MAX) ? ticks_next + 1'b1 : ticks_next;
        ticks_next = tick_inc;
        if (tick_inc == vlong_thr) begin
          flags_next = flags_next | FL_VLONG;
        end else if (tick_inc == long_thr) begin
          flags_next = flags_next | FL_LONG;
        end else if (tick_inc == short_thr) begin
          flags_next = flags_next | FL_SHORT;
        end
        if (tick_inc > vlong_thr) begin
          status_next = ST_TIMEOUT;
        end
      end
    end else begin
      flags_next = cur_flags & ~in_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVERS; i++) begin
        last_sample[i]  <= '0;
        press_status[i] <= ST_IDLE;
        press_ticks[i]  <= '0;
        flag_bits[i]    <= '0;
      end
    end else if (do_step && id_ok) begin
      last_sample[idx]  <= sample_next;
      press_status[idx] <= status_next;
      press_ticks[idx]  <= ticks_next;
      flag_bits[idx]    <= flags_next;
    end
  end

  // Result register. An out-of-range lever gives zero value, flags and status.
  logic [SampleW-1:0] res_value;
  logic [FlagW-1:0]   res_flags;
  logic [StatusW-1:0] res_status;
  logic               res_all_set;
  logic [FlagW-1:0]   out_flags;

  assign out_flags = id_ok ? flags_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      res_value   <= id_ok ? sample_next : '0;
      res_flags   <= out_flags;
      res_status  <= id_ok ? status_next : ST_IDLE;
      res_all_set <= ((out_flags & in_mask) == in_mask);
    end
  end

  assign out_ch.valid          = res_valid;
  assign out_ch.lever_value    = res_value;
  assign out_ch.event_flags    = res_flags;
  assign out_ch.lever_status   = res_status;
  assign out_ch.masked_all_set = res_all_set;

endmodule

`default_nettype wire

// ===== dv/tb_lever_press_duration_classifier.sv =====
// Self-checking testbench for the lever press duration classifier.
`timescale 1ns / 1ps

module tb_lever_press_duration_classifier;
  import lpdc_pkg::*;

  localparam int NUM_LEVERS   = NumLeversDefault;
  // A request in flight sits only in the input or the result register, and these quiet
  // cycles cover anything still in flight.
  localparam int DRAIN_CYCLES = 8;
  // Longest honest quiet stretch is the longest sender gap stacked on the longest
  // result stall plus the pipeline; this is many times that.
  localparam int QUIET_LIMIT  = 2000;

  typedef struct packed {
    logic               kind;
    logic               lever_id;
    logic [SampleW-1:0] sample;
    logic [FlagW-1:0]   flag_mask;
  } lever_req_t;

  typedef struct packed {
    logic [SampleW-1:0] lever_value;
    logic [FlagW-1:0]   event_flags;
    logic [StatusW-1:0] lever_status;
    logic               masked_all_set;
  } lever_result_t;

  logic clk;
  logic rst;

  lpdc_in_if  in_ch();
  lpdc_out_if out_ch();
  lpdc_cfg_if cfg_ch();

  lever_press_duration_classifier dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the per-lever press state and the threshold registers.
  logic [SampleW-1:0] seen_sample [NUM_LEVERS];
  logic [StatusW-1:0] press_state [NUM_LEVERS];
  logic [TickW-1:0]   hold_ticks  [NUM_LEVERS];
  logic [FlagW-1:0]   lever_flags [NUM_LEVERS];
  logic [TickW-1:0]   short_thr, long_thr, vlong_thr;

  lever_result_t pending_results [$];

  int unsigned max_gap;       // longest sender pause before a request
  int unsigned sink_max;      // longest result stall after an accepted result
  int unsigned ready_hold;
  int unsigned quiet_cycles;
  int unsigned failures;
  int unsigned n_requests, n_clears, n_results, n_pops, n_timeouts, n_settings;

  // Applies one request to the lever state and returns the result it must produce.
  function automatic lever_result_t advance_lever(lever_req_t req);
    lever_result_t res;
    logic [TickW-1:0] t;
    int unsigned id;
    id  = req.lever_id;
    res = '0;
    if (id < NUM_LEVERS) begin
      if (req.kind == KIND_SCAN) begin
        // A changed sample is latched; nonzero starts a fresh press, zero ends it.
        if (seen_sample[id] != req.sample) begin
          seen_sample[id] = req.sample;
          if (req.sample != '0) begin
            press_state[id] = ST_PUSHED;
            hold_ticks[id]  = '0;
            lever_flags[id] = lever_flags[id] & ~FL_PRESS_ALL;
          end else if (hold_ticks[id] >= short_thr) begin
            press_state[id] = ST_POPPED;
            lever_flags[id] = lever_flags[id] | FL_POP;
          end else begin
            press_state[id] = ST_IDLE;
          end
        end
        // While pushed, count the tick (saturating) and raise at most one flag,
        // very long ahead of long ahead of short.
        if (press_state[id] == ST_PUSHED) begin
          t = hold_ticks[id];
          if (t != TICK_MAX) t = t + 1'b1;
          hold_ticks[id] = t;
          if (t == vlong_thr) lever_flags[id] = lever_flags[id] | FL_VLONG;
          else if (t == long_thr) lever_flags[id] = lever_flags[id] | FL_LONG;
          else if (t == short_thr) lever_flags[id] = lever_flags[id] | FL_SHORT;
          if (t > vlong_thr) press_state[id] = ST_TIMEOUT;
        end
      end else begin
        lever_flags[id] = lever_flags[id] & ~req.flag_mask;
      end
      res.lever_value  = seen_sample[id];
      res.event_flags  = lever_flags[id];
      res.lever_status = press_state[id];
    end
    res.masked_all_set = ((res.event_flags & req.flag_mask) == req.flag_mask);
    return res;
  endfunction

  function automatic logic [SampleW-1:0] random_press_value();
    case ($urandom_range(3, 0))
      0:       return 16'hFFFF;
      1:       return 16'h0001 << $urandom_range(15, 0);
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  // Sends one request. Called at a falling edge and returns at a falling edge
  // with valid still high, so back-to-back requests never toggle valid in one step.
  task automatic send_request(input logic kind, input logic lever_id,
                              input logic [SampleW-1:0] sample,
                              input logic [FlagW-1:0] flag_mask);
    lever_req_t req;
    int unsigned gap;
    req = '{kind: kind, lever_id: lever_id, sample: sample, flag_mask: flag_mask};
    gap = $urandom_range(max_gap, 0);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= req.kind;
    in_ch.lever_id  <= req.lever_id;
    in_ch.sample    <= req.sample;
    in_ch.flag_mask <= req.flag_mask;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(advance_lever(req));
    n_requests++;
    if (req.kind == KIND_CLEAR) n_clears++;
    @(negedge clk);
  endtask

  // Holds off new requests until every expected result is back, then lets the
  // pipeline settle. Configuration writes happen only after this.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_thresholds(input logic [TickW-1:0] short_val,
                                 input logic [TickW-1:0] long_val,
                                 input logic [TickW-1:0] vlong_val);
    logic [CfgIdxW-1:0] idx  [3];
    logic [TickW-1:0]   vals [3];
    idx  = '{REG_SHORT_THR, REG_LONG_THR, REG_VLONG_THR};
    vals = '{short_val, long_val, vlong_val};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid     <= 1'b1;
      cfg_ch.reg_index <= idx[i];
      cfg_ch.data      <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx[i])
        REG_SHORT_THR: short_thr = vals[i];
        REG_LONG_THR:  long_thr  = vals[i];
        REG_VLONG_THR: vlong_thr = vals[i];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // Requests on idle levers under reset thresholds, then one full press walked
  // through every flag, timeout and pop, a release before the short threshold,
  // a press restarted by a new sample, and clears with empty and full masks.
  task automatic test_directed();
    max_gap  = 16;
    sink_max = 16;
    send_request(KIND_CLEAR, 1'b0, 16'hFFFF, 4'hF);  // sample must be ignored
    send_request(KIND_CLEAR, 1'b1, 16'h0000, 4'h0);  // empty mask reads as all set
    send_request(KIND_SCAN,  1'b0, 16'h0000, 4'h0);  // released and unchanged
    wait_for_results();
    load_thresholds(10'd2, 10'd3, 10'd4);
    send_request(KIND_SCAN,  1'b0, 16'hFFFF, FL_SHORT);
    send_request(KIND_SCAN,  1'b0, 16'hFFFF, FL_SHORT);
    send_request(KIND_SCAN,  1'b0, 16'hFFFF, FL_LONG);
    send_request(KIND_SCAN,  1'b0, 16'hFFFF, FL_VLONG);
    send_request(KIND_SCAN,  1'b0, 16'hFFFF, FL_PRESS_ALL);
    send_request(KIND_SCAN,  1'b0, 16'h0000, FL_POP);
    send_request(KIND_CLEAR, 1'b0, 16'h1234, FL_POP | FL_SHORT);
    send_request(KIND_SCAN,  1'b1, 16'h0001, 4'h0);
    send_request(KIND_SCAN,  1'b1, 16'h0000, FL_POP);  // too short to pop
    send_request(KIND_SCAN,  1'b1, 16'h8000, 4'h0);
    send_request(KIND_SCAN,  1'b1, 16'h7FFF, 4'h0);    // new sample restarts the press
    send_request(KIND_CLEAR, 1'b1, 16'h0000, 4'hF);
  endtask

  // Equal thresholds let only the highest-priority flag rise; zero thresholds
  // raise nothing and time out on the first tick.
  task automatic test_threshold_corners();
    wait_for_results();
    load_thresholds(10'd3, 10'd3, 10'd3);
    repeat (4) send_request(KIND_SCAN, 1'b0, 16'h1234, FL_VLONG);
    send_request(KIND_SCAN, 1'b0, 16'h0000, 4'hF);
    wait_for_results();
    load_thresholds(10'd0, 10'd0, 10'd0);
    send_request(KIND_SCAN,  1'b1, 16'h0F0F, FL_PRESS_ALL);
    send_request(KIND_SCAN,  1'b1, 16'h0000, FL_POP);
    send_request(KIND_CLEAR, 1'b1, 16'hF0F0, 4'hF);
  endtask

  // One long hold under wide thresholds: each flag rises on its own tick, the
  // status times out just past the very-long threshold, and the release pops.
  task automatic test_long_hold();
    max_gap  = 1;
    sink_max = 1;
    wait_for_results();
    load_thresholds(10'd1, 10'd150, 10'd300);
    repeat (305) send_request(KIND_SCAN, 1'b1, 16'hA5A5, 4'($urandom));
    send_request(KIND_SCAN, 1'b1, 16'h0000, 4'hF);
  endtask

  // Mostly well-formed presses of random length and value on both levers,
  // mixed with clears and stray samples, under several threshold settings.
  task automatic test_random_presses();
    logic [SampleW-1:0] held      [NUM_LEVERS];
    int unsigned        hold_left [NUM_LEVERS];
    int unsigned        lid, roll, hold_cap;
    logic [SampleW-1:0] s;
    held      = '{default: '0};
    hold_left = '{default: 0};
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_results();
      case (phase)
        0:       load_thresholds(SHORT_THR_RESET, LONG_THR_RESET, VLONG_THR_RESET);
        1:       load_thresholds(10'd1, 10'd1, 10'd1);
        default: load_thresholds(10'($urandom_range(8, 1)), 10'($urandom_range(20, 1)),
                                 10'($urandom_range(40, 1)));
      endcase
      // Some phases run with no idling on one side or both.
      max_gap  = (phase == 2 || phase == 5) ? 0 : 16;
      sink_max = (phase == 3 || phase == 5) ? 0 : 16;
      hold_cap = (vlong_thr + 3 > 45) ? 45 : vlong_thr + 3;
      repeat (70) begin
        roll = $urandom_range(99, 0);
        lid  = $urandom_range(NUM_LEVERS - 1, 0);
        if (roll < 12) begin
          send_request(KIND_CLEAR, 1'(lid), 16'($urandom), 4'($urandom));
        end else if (roll < 20) begin
          // Stray sample: may change a running press or release it early.
          s = ($urandom_range(1, 0) != 0) ? 16'($urandom) : '0;
          held[lid]      = s;
          hold_left[lid] = $urandom_range(hold_cap, 0);
          send_request(KIND_SCAN, 1'(lid), s, 4'($urandom));
        end else if (held[lid] == '0) begin
          if ($urandom_range(2, 0) != 0) begin
            held[lid]      = random_press_value();
            hold_left[lid] = $urandom_range(hold_cap, 0);
          end
          send_request(KIND_SCAN, 1'(lid), held[lid], 4'($urandom));
        end else if (hold_left[lid] != 0) begin
          hold_left[lid]--;
          send_request(KIND_SCAN, 1'(lid), held[lid], 4'($urandom));
        end else begin
          held[lid] = '0;
          send_request(KIND_SCAN, 1'(lid), '0, 4'($urandom));
        end
        // Now and then stop sending until the result side has caught up.
        if ($urandom_range(149, 0) == 0) wait_for_results();
      end
    end
  endtask

  // Result stall: after each accepted result, ready drops for a drawn number of cycles.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every accepted result is matched against the oldest expected one.
  always @(posedge clk) begin : result_check
    lever_result_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{lever_value: out_ch.lever_value, event_flags: out_ch.event_flags,
              lever_status: out_ch.lever_status, masked_all_set: out_ch.masked_all_set};
      n_results++;
      ready_hold = $urandom_range(sink_max, 0);
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] result with none expected: value=%h flags=%b status=%0d all=%b",
                   $realtime, got.lever_value, got.event_flags, got.lever_status,
                   got.masked_all_set);
      end else begin
        want = pending_results.pop_front();
        if (want.lever_status == ST_POPPED) n_pops++;
        if (want.lever_status == ST_TIMEOUT) n_timeouts++;
        if (got.lever_value !== want.lever_value || got.event_flags !== want.event_flags ||
            got.lever_status !== want.lever_status ||
            got.masked_all_set !== want.masked_all_set) begin
          failures++;
          if (failures <= 10) begin
            $display("[%0t] result %0d mismatch: expected value=%h flags=%b status=%0d all=%b",
                     $realtime, n_results, want.lever_value, want.event_flags,
                     want.lever_status, want.masked_all_set);
            $display("[%0t] result %0d mismatch: got      value=%h flags=%b status=%0d all=%b",
                     $realtime, n_results, got.lever_value, got.event_flags,
                     got.lever_status, got.masked_all_set);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no handshake on any channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles, %0d results still expected.",
                 quiet_cycles, pending_results.size());
        $display("** lever_press_duration_classifier: FAILED **");
        $finish;
      end
    end
  end

  initial begin : main_sequence
    clk              = 1'b0;
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_SCAN;
    in_ch.lever_id   = 1'b0;
    in_ch.sample     = '0;
    in_ch.flag_mask  = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_SHORT_THR;
    cfg_ch.data      = '0;
    max_gap          = 16;
    sink_max         = 16;
    ready_hold       = 0;
    quiet_cycles     = 0;
    failures         = 0;
    short_thr        = SHORT_THR_RESET;
    long_thr         = LONG_THR_RESET;
    vlong_thr        = VLONG_THR_RESET;
    for (int i = 0; i < NUM_LEVERS; i++) begin
      seen_sample[i] = '0;
      press_state[i] = ST_IDLE;
      hold_ticks[i]  = '0;
      lever_flags[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_threshold_corners();
    test_random_presses();
    test_long_hold();
    wait_for_results();

    if (pending_results.size() != 0) failures++;
    $display("Run covered %0d requests (%0d clears) and %0d results, %0d threshold settings.",
             n_requests, n_clears, n_results, n_settings);
    $display("Results in popped status: %0d, in timed-out status: %0d, failures: %0d.",
             n_pops, n_timeouts, failures);
    if (failures == 0) begin
      $display("** lever_press_duration_classifier: PASSED **");
    end else begin
      $display("** lever_press_duration_classifier: FAILED **");
    end
    $finish;
  end

endmodule

// ===== lever_press_duration_classifier.f =====
rtl/lpdc_pkg.sv
rtl/lpdc_if.sv
rtl/lever_press_duration_classifier.sv
dv/tb_lever_press_duration_classifier.sv
